// File: rtl/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared types, register map and helpers of the texture sampler.
// ----------------------------------------------------------------------------
package tsb_pkg;

    // register indexes on the config port (byte address = 4 * index)
    localparam logic [1:0] REG_TEX_WIDTH    = 2'd0;
    localparam logic [1:0] REG_TEX_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_ADDRESS_MODE = 2'd2;
    localparam logic [1:0] REG_FILTER_MODE  = 2'd3;

    // address modes, code 3 acts as clamp
    localparam logic [1:0] ADDR_WRAP   = 2'd0;
    localparam logic [1:0] ADDR_CLAMP  = 2'd1;
    localparam logic [1:0] ADDR_MIRROR = 2'd2;

    // filter modes
    localparam logic FILT_POINT    = 1'b0;
    localparam logic FILT_BILINEAR = 1'b1;

    // item kinds
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // per-axis settings handed to the coordinate unit
    typedef struct packed {
        logic [7:0] len;
        logic [1:0] mode;
        logic       filter;
    } axis_cfg_t;

    // bring a texel index back into [0, len-1]: wrap or saturate
    function automatic logic [7:0] fix_index(input logic signed [10:0] i,
                                             input logic [7:0] len,
                                             input logic wrap);
        logic signed [10:0] l;
        logic [7:0]         r;
        l = $signed({3'b0, len});
        if (i < 0)
            r = wrap ? len - 8'd1 : 8'd0;
        else if (i >= l)
            r = wrap ? 8'd0 : len - 8'd1;
        else
            r = i[7:0];
        return r;
    endfunction

endpackage

// File: rtl/tsb_if.sv
// ----------------------------------------------------------------------------
// tsb_req_if / tsb_rsp_if
// Valid/ready channels of the texture sampler: request and sampled color.
// ----------------------------------------------------------------------------
interface tsb_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [13:0]        texel_index;
    logic [7:0]         in_red;
    logic [7:0]         in_green;
    logic [7:0]         in_blue;
    logic [7:0]         in_alpha;
    logic signed [31:0] coord_u;
    logic signed [31:0] coord_v;

    modport source (output valid, req_type, texel_index, in_red, in_green, in_blue,
                    in_alpha, coord_u, coord_v, input ready);
    modport sink (input valid, req_type, texel_index, in_red, in_green, in_blue,
                  in_alpha, coord_u, coord_v, output ready);
endinterface

interface tsb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

// File: rtl/tsb_ram.sv
// ----------------------------------------------------------------------------
// tsb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/tsb_coord.sv
// ----------------------------------------------------------------------------
// tsb_coord
// Three-stage coordinate unit: address mode, scale to texel space, index fix-up.
// ----------------------------------------------------------------------------
module tsb_coord import tsb_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] coord,
    input  axis_cfg_t          cfg,
    output logic [7:0]         idx0,
    output logic [7:0]         idx1,
    output logic [7:0]         weight
);

    logic signed [32:0] a;
    logic signed [8:0]  len_s;
    logic signed [41:0] prod_next, prod_reg;
    logic signed [41:0] t, hi, tc;
    logic signed [17:0] fx_next, fx_reg;
    logic signed [17:0] fsum;
    logic signed [10:0] ib;
    logic [7:0]         i0, i1;
    logic               wrap, clamp, bilin;
    logic [7:0]         idx0_reg, idx1_reg, weight_reg;

    assign wrap  = (cfg.mode == ADDR_WRAP);
    assign clamp = (cfg.mode != ADDR_WRAP) && (cfg.mode != ADDR_MIRROR);
    assign bilin = (cfg.filter == FILT_BILINEAR);
    assign len_s = $signed({1'b0, cfg.len});

    // stage 1: fold the coordinate per address mode, scale by the length
    always_comb
    begin
        case (cfg.mode)
            ADDR_WRAP:   a = $signed({17'b0, coord[15:0]});
            ADDR_MIRROR: a = coord[16] ? 33'sh10000 - $signed({17'b0, coord[15:0]})
                                       : $signed({17'b0, coord[15:0]});
            default:     a = $signed({coord[31], coord});
        endcase
        prod_next = a * len_s;
    end

    // stage 2: down to 8 fraction bits, clamp, minus half a texel
    always_comb
    begin
        t  = prod_reg >>> 8;
        hi = $signed({26'b0, cfg.len, 8'b0}) - 42'sd128;
        tc = t;
        if (clamp)
        begin
            if (tc < 42'sd128)
                tc = 42'sd128;
            if (tc > hi)
                tc = hi;
        end
        fx_next = 18'(tc - 42'sd128);
    end

    // stage 3: integer index, neighbor and weight
    always_comb
    begin
        fsum = bilin ? fx_reg : fx_reg + 18'sd128;
        ib   = 11'(fsum >>> 8);
        i0   = fix_index(ib, cfg.len, wrap);
        i1   = bilin ? fix_index($signed({3'b0, i0}) + 11'sd1, cfg.len, wrap) : i0;
    end

    // pipeline registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            fx_reg     <= fx_next;
            idx0_reg   <= i0;
            idx1_reg   <= i1;
            weight_reg <= bilin ? fx_reg[7:0] : 8'd0;
        end
    end

    assign idx0   = idx0_reg;
    assign idx1   = idx1_reg;
    assign weight = weight_reg;

endmodule

// File: rtl/texture_sampler_bilinear.sv
// ----------------------------------------------------------------------------
// texture_sampler_bilinear
// RGBA8 texture sampler with wrap, clamp and mirror addressing and point or
// bilinear filtering, fed by load and sample items.
// ----------------------------------------------------------------------------
// The sampler takes one item every clock unless stalled and returns a sample
// item's color; load items give no result. The pipeline is three stages of
// coordinate mapping, one of texel address multiply, one texel store read,
// and two stages of horizontal and vertical blend. The texel store is held
// in four identical copies, one per bilinear neighbor, all written by every
// in-range load, so the four neighbors are read together. A stall on the
// result side holds the whole pipeline. Configuration must be written over
// the APB-style port while no item is in flight; nothing here enforces it.
module texture_sampler_bilinear import tsb_pkg::*; #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tsb_req_if.sink     req,
    tsb_rsp_if.source   rsp
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
    localparam int CAP_H = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;

    // configuration registers
    logic [7:0] tex_width_reg, tex_height_reg;
    logic [1:0] address_mode_reg;
    logic       filter_mode_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg    <= 8'd128;
            tex_height_reg   <= 8'd128;
            address_mode_reg <= ADDR_WRAP;
            filter_mode_reg  <= FILT_BILINEAR;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_TEX_WIDTH:    tex_width_reg    <= pwdata[7:0];
                REG_TEX_HEIGHT:   tex_height_reg   <= pwdata[7:0];
                REG_ADDRESS_MODE: address_mode_reg <= pwdata[1:0];
                REG_FILTER_MODE:  filter_mode_reg  <= pwdata[0];
                default:          ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_TEX_WIDTH:    prdata = {24'b0, tex_width_reg};
            REG_TEX_HEIGHT:   prdata = {24'b0, tex_height_reg};
            REG_ADDRESS_MODE: prdata = {30'b0, address_mode_reg};
            REG_FILTER_MODE:  prdata = {31'b0, filter_mode_reg};
            default:          prdata = 32'b0;
        endcase
    end

    // effective sizes: zero reads as one, capped at the maximum
    logic [7:0] w_eff, h_eff;
    axis_cfg_t  cfg_u, cfg_v;

    always_comb
    begin
        if (tex_width_reg == 8'd0)
            w_eff = 8'd1;
        else if (32'(tex_width_reg) > CAP_W)
            w_eff = 8'(CAP_W);
        else
            w_eff = tex_width_reg;
        if (tex_height_reg == 8'd0)
            h_eff = 8'd1;
        else if (32'(tex_height_reg) > CAP_H)
            h_eff = 8'(CAP_H);
        else
            h_eff = tex_height_reg;
    end

    assign cfg_u = '{len: w_eff, mode: address_mode_reg, filter: filter_mode_reg};
    assign cfg_v = '{len: h_eff, mode: address_mode_reg, filter: filter_mode_reg};

    // global advance: the output register is free or being drained
    logic en;
    logic out_valid_reg;

    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    // stages 1 to 3: coordinate mapping, load payload rides alongside
    logic [7:0] x0, x1, y0, y1, wx, wy;

    tsb_coord u_coord_u (
        .clk    (clk),
        .en     (en),
        .coord  (req.coord_u),
        .cfg    (cfg_u),
        .idx0   (x0),
        .idx1   (x1),
        .weight (wx)
    );

    tsb_coord u_coord_v (
        .clk    (clk),
        .en     (en),
        .coord  (req.coord_v),
        .cfg    (cfg_v),
        .idx0   (y0),
        .idx1   (y1),
        .weight (wy)
    );

    logic [2:0]  p_valid_reg;
    logic [2:0]  p_sample_reg;
    logic [13:0] p_index_reg [3];
    logic [31:0] p_texel_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= '0;
        end
        else if (en)
        begin
            p_valid_reg <= {p_valid_reg[1:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_sample_reg   <= {p_sample_reg[1:0], req.req_type == REQ_SAMPLE};
            p_index_reg[0] <= req.texel_index;
            p_texel_reg[0] <= {req.in_alpha, req.in_blue, req.in_green, req.in_red};
            p_index_reg[1] <= p_index_reg[0];
            p_texel_reg[1] <= p_texel_reg[0];
            p_index_reg[2] <= p_index_reg[1];
            p_texel_reg[2] <= p_texel_reg[1];
        end
    end

    // stage 4: store addresses of the four neighbors, load write request
    logic [15:0]   a00, a01, a10, a11;
    logic [AW-1:0] raddr_reg [4];
    logic [AW-1:0] waddr_reg;
    logic [31:0]   wdata_reg;
    logic          s4_valid_reg, s4_sample_reg;
    logic [7:0]    s4_wx_reg, s4_wy_reg;
    logic          we;

    always_comb
    begin
        a00 = 16'(y0) * 16'(w_eff) + {8'b0, x0};
        a01 = 16'(y0) * 16'(w_eff) + {8'b0, x1};
        a10 = 16'(y1) * 16'(w_eff) + {8'b0, x0};
        a11 = 16'(y1) * 16'(w_eff) + {8'b0, x1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= p_valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_sample_reg <= p_sample_reg[2];
            raddr_reg[0]  <= AW'(a00);
            raddr_reg[1]  <= AW'(a01);
            raddr_reg[2]  <= AW'(a10);
            raddr_reg[3]  <= AW'(a11);
            waddr_reg     <= AW'(p_index_reg[2]);
            wdata_reg     <= p_texel_reg[2];
            s4_wx_reg     <= wx;
            s4_wy_reg     <= wy;
        end
    end

    // loads beyond the store depth are dropped
    logic [13:0] waddr_hold;
    logic        s4_in_range;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            waddr_hold <= p_index_reg[2];
        end
    end

    assign s4_in_range = (32'(waddr_hold) < DEPTH);
    assign we = en && s4_valid_reg && !s4_sample_reg && s4_in_range;

    // stage 5: four copies of the texel store, one per neighbor
    logic [31:0] texel [4];

    for (genvar g = 0; g < 4; g++)
    begin : g_store
        tsb_ram #(
            .WIDTH (32),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (waddr_reg),
            .wdata (wdata_reg),
            .re    (en),
            .raddr (raddr_reg[g]),
            .rdata (texel[g])
        );
    end

    logic       s5_valid_reg;
    logic [7:0] s5_wx_reg, s5_wy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= s4_valid_reg && s4_sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_wx_reg <= s4_wx_reg;
            s5_wy_reg <= s4_wy_reg;
        end
    end

    // stage 6: horizontal blend of both rows, per channel
    logic [15:0] top_next [4];
    logic [15:0] bot_next [4];
    logic [15:0] top_reg  [4];
    logic [15:0] bot_reg  [4];
    logic [8:0]  iwx;
    logic        s6_valid_reg;
    logic [7:0]  s6_wy_reg;

    assign iwx = 9'd256 - {1'b0, s5_wx_reg};

    always_comb
    begin
        for (int ch = 0; ch < 4; ch++)
        begin
            top_next[ch] = 16'(texel[0][8*ch +: 8]) * 16'(iwx)
                         + 16'(texel[1][8*ch +: 8]) * 16'(s5_wx_reg);
            bot_next[ch] = 16'(texel[2][8*ch +: 8]) * 16'(iwx)
                         + 16'(texel[3][8*ch +: 8]) * 16'(s5_wx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top_reg   <= top_next;
            bot_reg   <= bot_next;
            s6_wy_reg <= s5_wy_reg;
        end
    end

    // stage 7: vertical blend and round half up into the output register
    logic [8:0]  iwy;
    logic [24:0] r_sum [4];
    logic [7:0]  color_next [4];
    logic [7:0]  color_reg  [4];

    assign iwy = 9'd256 - {1'b0, s6_wy_reg};

    always_comb
    begin
        for (int ch = 0; ch < 4; ch++)
        begin
            r_sum[ch] = 25'(top_reg[ch]) * 25'(iwy) + 25'(bot_reg[ch]) * 25'(s6_wy_reg)
                      + 25'd32768;
            color_next[ch] = r_sum[ch][23:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            color_reg <= color_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_red   = color_reg[0];
    assign rsp.out_green = color_reg[1];
    assign rsp.out_blue  = color_reg[2];
    assign rsp.out_alpha = color_reg[3];

endmodule
